// File: rtl/core/iqs_pkg.sv
// Package for the iterative quicksort block: data width, default store size
// and the controller state encoding. No dependencies.
package iqs_pkg;

  localparam int unsigned DATA_W        = 32;
  localparam int unsigned MAX_ELEMS_DEF = 64;

  // Controller states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_POP,
    S_RANGE,
    S_PIVOT,
    S_RDJ,
    S_CMP,
    S_SW1,
    S_SW2,
    S_FRD,
    S_FW1,
    S_FW2,
    S_PUSHL,
    S_PUSHR,
    S_EMRD,
    S_EMLD
  } iqs_state_e;

endpackage

// File: rtl/core/iterative_quicksort.sv
// Top level of the iterative quicksort block: element store, range stack
// and controller. Depends on iqs_pkg, iqs_store, iqs_stack and iqs_ctrl.
//
//   Channel  Direction  Handshake                 Beat payload
//   input    in         in_valid_i / in_stall_o   value_i, last_i
//   output   out        out_valid_o / out_stall_i sorted_value_o, last_res_o,
//                                                  truncated_o
//
// Loading accepts one beat per cycle while the input is not stalled. After the
// last beat the sort runs in the element store, paced by its one read port and
// one write port. Each result is then read from the store and loaded into the
// output register; the read waits while an untaken result is still held there.
// Reset clears the controller only; the memories need no clearing pass.
// The input is stalled from the last beat until the final result is loaded.
module iterative_quicksort #(
  parameter int unsigned MAX_ELEMS = iqs_pkg::MAX_ELEMS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic signed [iqs_pkg::DATA_W-1:0] value_i,
  input  logic                       last_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [iqs_pkg::DATA_W-1:0] sorted_value_o,
  output logic                       last_res_o,
  output logic                       truncated_o
);

  localparam int unsigned IDX_W = $clog2(MAX_ELEMS);
  localparam int unsigned CNT_W = $clog2(MAX_ELEMS + 1);

  logic                       st_we;
  logic [IDX_W-1:0]           st_waddr;
  logic [iqs_pkg::DATA_W-1:0] st_wdata;
  logic [IDX_W-1:0]           st_raddr;
  logic [iqs_pkg::DATA_W-1:0] st_rdata;
  logic                       sk_we;
  logic [IDX_W-1:0]           sk_waddr;
  logic [2*IDX_W-1:0]         sk_wdata;
  logic [IDX_W-1:0]           sk_raddr;
  logic [2*IDX_W-1:0]         sk_rdata;
  logic [iqs_pkg::DATA_W-1:0] out_data;

  // Element store.
  iqs_store #(
    .DEPTH (MAX_ELEMS),
    .AW    (IDX_W)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  // Range stack.
  iqs_stack #(
    .DEPTH (MAX_ELEMS),
    .AW    (IDX_W),
    .DW    (2 * IDX_W)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (sk_we),
    .waddr_i (sk_waddr),
    .wdata_i (sk_wdata),
    .raddr_i (sk_raddr),
    .rdata_o (sk_rdata)
  );

  // Controller.
  iqs_ctrl #(
    .MAX_ELEMS (MAX_ELEMS),
    .IDX_W     (IDX_W),
    .CNT_W     (CNT_W)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .value_i        (value_i),
    .last_i         (last_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .sorted_value_o (out_data),
    .last_res_o     (last_res_o),
    .truncated_o    (truncated_o),
    .st_we_o        (st_we),
    .st_waddr_o     (st_waddr),
    .st_wdata_o     (st_wdata),
    .st_raddr_o     (st_raddr),
    .st_rdata_i     (st_rdata),
    .sk_we_o        (sk_we),
    .sk_waddr_o     (sk_waddr),
    .sk_wdata_o     (sk_wdata),
    .sk_raddr_o     (sk_raddr),
    .sk_rdata_i     (sk_rdata)
  );

  assign sorted_value_o = $signed(out_data);

endmodule

// File: rtl/core/iqs_store.sv
// Element store: one write port and one read port with a registered read.
// Depends on iqs_pkg for the data width.
module iqs_store #(
  parameter int unsigned DEPTH = iqs_pkg::MAX_ELEMS_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [AW-1:0]              waddr_i,
  input  logic [iqs_pkg::DATA_W-1:0] wdata_i,
  input  logic [AW-1:0]              raddr_i,
  output logic [iqs_pkg::DATA_W-1:0] rdata_o
);

  logic [iqs_pkg::DATA_W-1:0] mem_q [DEPTH];
  logic [iqs_pkg::DATA_W-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/iqs_stack.sv
// Range stack memory: holds pending (low, high) index pairs, one per entry.
// Registered read; depends on iqs_pkg for the default depth.
module iqs_stack #(
  parameter int unsigned DEPTH = iqs_pkg::MAX_ELEMS_DEF,
  parameter int unsigned AW    = $clog2(DEPTH),
  parameter int unsigned DW    = 2 * AW
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  // Push writes one pair.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Pop reads one pair, available the next cycle.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/iqs_ctrl.sv
// Sort controller: loads the batch, runs Lomuto partitioning through the
// element store and range stack, then emits results. Depends on iqs_pkg.
module iqs_ctrl #(
  parameter int unsigned MAX_ELEMS = iqs_pkg::MAX_ELEMS_DEF,
  parameter int unsigned IDX_W     = $clog2(MAX_ELEMS),
  parameter int unsigned CNT_W     = $clog2(MAX_ELEMS + 1)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // Input channel.
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [iqs_pkg::DATA_W-1:0] value_i,
  input  logic                       last_i,
  // Output channel.
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [iqs_pkg::DATA_W-1:0] sorted_value_o,
  output logic                       last_res_o,
  output logic                       truncated_o,
  // Element store port.
  output logic                       st_we_o,
  output logic [IDX_W-1:0]           st_waddr_o,
  output logic [iqs_pkg::DATA_W-1:0] st_wdata_o,
  output logic [IDX_W-1:0]           st_raddr_o,
  input  logic [iqs_pkg::DATA_W-1:0] st_rdata_i,
  // Range stack port.
  output logic                       sk_we_o,
  output logic [IDX_W-1:0]           sk_waddr_o,
  output logic [2*IDX_W-1:0]         sk_wdata_o,
  output logic [IDX_W-1:0]           sk_raddr_o,
  input  logic [2*IDX_W-1:0]         sk_rdata_i
);

  iqs_pkg::iqs_state_e state_q, state_d;

  logic [CNT_W-1:0]           cnt_q, cnt_d;
  logic                       ovf_q, ovf_d;
  logic [CNT_W-1:0]           sp_q, sp_d;
  logic [IDX_W-1:0]           lo_q, lo_d, hi_q, hi_d;
  logic [IDX_W-1:0]           j_q, j_d, k_q, k_d, e_q, e_d;
  logic [iqs_pkg::DATA_W-1:0] pivot_q, pivot_d, tmp_q, tmp_d;
  logic                       ov_q, ov_d, ol_q, ol_d, ot_q, ot_d;
  logic [iqs_pkg::DATA_W-1:0] od_q, od_d;

  logic             in_beat;
  logic             out_free;
  logic             le_pivot;
  logic             j_end;
  logic             push_l;
  logic             push_r;
  logic             e_last;
  logic [IDX_W-1:0] pop_lo;
  logic [IDX_W-1:0] pop_hi;

  // Shared conditions.
  assign in_stall_o = (state_q != iqs_pkg::S_IDLE);
  assign in_beat    = in_valid_i && !in_stall_o;
  assign out_free   = !ov_q || !out_stall_i;
  assign le_pivot   = $signed(st_rdata_i) <= $signed(pivot_q);
  assign j_end      = (CNT_W'(j_q) + CNT_W'(1)) == CNT_W'(hi_q);
  assign push_l     = CNT_W'(k_q) > (CNT_W'(lo_q) + CNT_W'(1));
  assign push_r     = (CNT_W'(k_q) + CNT_W'(1)) < CNT_W'(hi_q);
  assign e_last     = CNT_W'(e_q) == (cnt_q - CNT_W'(1));
  assign pop_lo     = sk_rdata_i[2*IDX_W-1:IDX_W];
  assign pop_hi     = sk_rdata_i[IDX_W-1:0];

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      iqs_pkg::S_IDLE:  if (in_beat && last_i) state_d = iqs_pkg::S_START;
      iqs_pkg::S_START: state_d = (cnt_q < CNT_W'(2)) ? iqs_pkg::S_EMRD : iqs_pkg::S_POP;
      iqs_pkg::S_POP:   state_d = iqs_pkg::S_RANGE;
      iqs_pkg::S_RANGE: state_d = iqs_pkg::S_PIVOT;
      iqs_pkg::S_PIVOT: state_d = iqs_pkg::S_RDJ;
      iqs_pkg::S_RDJ:   state_d = iqs_pkg::S_CMP;
      iqs_pkg::S_CMP: begin
        if (le_pivot) begin
          state_d = iqs_pkg::S_SW1;
        end else begin
          state_d = j_end ? iqs_pkg::S_FRD : iqs_pkg::S_RDJ;
        end
      end
      iqs_pkg::S_SW1:   state_d = iqs_pkg::S_SW2;
      iqs_pkg::S_SW2:   state_d = j_end ? iqs_pkg::S_FRD : iqs_pkg::S_RDJ;
      iqs_pkg::S_FRD:   state_d = iqs_pkg::S_FW1;
      iqs_pkg::S_FW1:   state_d = iqs_pkg::S_FW2;
      iqs_pkg::S_FW2:   state_d = iqs_pkg::S_PUSHL;
      iqs_pkg::S_PUSHL: state_d = iqs_pkg::S_PUSHR;
      iqs_pkg::S_PUSHR: begin
        state_d = (sp_d == '0) ? iqs_pkg::S_EMRD : iqs_pkg::S_POP;
      end
      iqs_pkg::S_EMRD:  if (out_free) state_d = iqs_pkg::S_EMLD;
      iqs_pkg::S_EMLD:  state_d = e_last ? iqs_pkg::S_IDLE : iqs_pkg::S_EMRD;
      default:          state_d = iqs_pkg::S_IDLE;
    endcase
  end

  // Memory controls and datapath updates.
  always_comb begin
    cnt_d      = cnt_q;
    ovf_d      = ovf_q;
    sp_d       = sp_q;
    lo_d       = lo_q;
    hi_d       = hi_q;
    j_d        = j_q;
    k_d        = k_q;
    e_d        = e_q;
    pivot_d    = pivot_q;
    tmp_d      = tmp_q;
    ol_d       = ol_q;
    ot_d       = ot_q;
    od_d       = od_q;
    st_we_o    = 1'b0;
    st_waddr_o = k_q;
    st_wdata_o = tmp_q;
    st_raddr_o = j_q;
    sk_we_o    = 1'b0;
    sk_waddr_o = sp_q[IDX_W-1:0];
    sk_wdata_o = {lo_q, hi_q};
    sk_raddr_o = IDX_W'(sp_q - CNT_W'(1));
    // A result leaves the output register when it is taken.
    ov_d       = ov_q && out_stall_i;

    unique case (state_q)
      iqs_pkg::S_IDLE: begin
        if (in_beat) begin
          if (cnt_q < CNT_W'(MAX_ELEMS)) begin
            st_we_o    = 1'b1;
            st_waddr_o = cnt_q[IDX_W-1:0];
            st_wdata_o = value_i;
            cnt_d      = cnt_q + CNT_W'(1);
          end else begin
            ovf_d = 1'b1;
          end
        end
      end
      // Seed the stack with the whole batch.
      iqs_pkg::S_START: begin
        if (cnt_q >= CNT_W'(2)) begin
          sk_we_o    = 1'b1;
          sk_waddr_o = '0;
          sk_wdata_o = {IDX_W'(0), IDX_W'(cnt_q - CNT_W'(1))};
          sp_d       = CNT_W'(1);
        end
        e_d = '0;
      end
      iqs_pkg::S_POP: begin
        sp_d = sp_q - CNT_W'(1);
      end
      // Range arrives from the stack; fetch the pivot at its high end.
      iqs_pkg::S_RANGE: begin
        lo_d       = pop_lo;
        hi_d       = pop_hi;
        st_raddr_o = pop_hi;
      end
      iqs_pkg::S_PIVOT: begin
        pivot_d = st_rdata_i;
        j_d     = lo_q;
        k_d     = lo_q;
      end
      iqs_pkg::S_RDJ: begin
        st_raddr_o = j_q;
      end
      // Element j is compared; a small one is swapped to slot k.
      iqs_pkg::S_CMP: begin
        if (le_pivot) begin
          tmp_d      = st_rdata_i;
          st_raddr_o = k_q;
        end else begin
          j_d = j_q + IDX_W'(1);
        end
      end
      iqs_pkg::S_SW1: begin
        st_we_o    = 1'b1;
        st_waddr_o = k_q;
        st_wdata_o = tmp_q;
        tmp_d      = st_rdata_i;
      end
      iqs_pkg::S_SW2: begin
        st_we_o    = 1'b1;
        st_waddr_o = j_q;
        st_wdata_o = tmp_q;
        j_d        = j_q + IDX_W'(1);
        k_d        = k_q + IDX_W'(1);
      end
      // Pivot moves to its final slot k.
      iqs_pkg::S_FRD: begin
        st_raddr_o = k_q;
      end
      iqs_pkg::S_FW1: begin
        st_we_o    = 1'b1;
        st_waddr_o = k_q;
        st_wdata_o = pivot_q;
        tmp_d      = st_rdata_i;
      end
      iqs_pkg::S_FW2: begin
        st_we_o    = 1'b1;
        st_waddr_o = hi_q;
        st_wdata_o = tmp_q;
      end
      // Push the sides that still hold two or more elements.
      iqs_pkg::S_PUSHL: begin
        if (push_l) begin
          sk_we_o    = 1'b1;
          sk_wdata_o = {lo_q, k_q - IDX_W'(1)};
          sp_d       = sp_q + CNT_W'(1);
        end
      end
      iqs_pkg::S_PUSHR: begin
        if (push_r) begin
          sk_we_o    = 1'b1;
          sk_wdata_o = {k_q + IDX_W'(1), hi_q};
          sp_d       = sp_q + CNT_W'(1);
        end
      end
      iqs_pkg::S_EMRD: begin
        st_raddr_o = e_q;
      end
      // Load one result; the last one also closes the batch.
      iqs_pkg::S_EMLD: begin
        ov_d = 1'b1;
        od_d = st_rdata_i;
        ol_d = e_last;
        ot_d = ovf_q;
        if (e_last) begin
          cnt_d = '0;
          ovf_d = 1'b0;
          sp_d  = '0;
          e_d   = '0;
        end else begin
          e_d = e_q + IDX_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= iqs_pkg::S_IDLE;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
      sp_q    <= '0;
      e_q     <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ovf_q   <= ovf_d;
      sp_q    <= sp_d;
      e_q     <= e_d;
      ov_q    <= ov_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    j_q     <= j_d;
    k_q     <= k_d;
    pivot_q <= pivot_d;
    tmp_q   <= tmp_d;
    od_q    <= od_d;
    ol_q    <= ol_d;
    ot_q    <= ot_d;
  end

  assign out_valid_o    = ov_q;
  assign sorted_value_o = od_q;
  assign last_res_o     = ol_q;
  assign truncated_o    = ot_q;

endmodule

// File: verif/tb_top.sv
// Self-checking testbench for iterative_quicksort: drives batches of signed
// values and checks each sorted beat against an in-bench sorting predictor.
// Depends on iqs_pkg and the iterative_quicksort RTL.
module tb_top;

  typedef logic signed [iqs_pkg::DATA_W-1:0] word_t;

  // One expected output beat.
  typedef struct {
    word_t value;
    logic  last;
    logic  trunc;
  } result_t;

  // One row of the directed stimulus table.
  typedef struct {
    word_t value;
    logic  last;
    int    reps;
    bit    typed;
    word_t exp_value;
    logic  exp_trunc;
  } stim_row_t;

  localparam int    ELEMS      = 64;
  localparam int    DIR_ROWS   = 20;
  localparam int    RAND_ITEMS = 176;
  localparam int    LIMIT      = 1000000;
  localparam word_t WORD_MAX   = 32'sh7fff_ffff;
  localparam word_t WORD_MIN   = 32'sh8000_0000;

  logic  clk_i       = 1'b0;
  logic  rst_ni      = 1'b0;
  logic  in_valid_i  = 1'b0;
  logic  in_stall_o;
  word_t value_i     = '0;
  logic  last_i      = 1'b0;
  logic  out_valid_o;
  logic  out_stall_i = 1'b0;
  word_t sorted_value_o;
  logic  last_res_o;
  logic  truncated_o;

  // Predictor state: the batch being collected and its dropped flag.
  word_t     held_q[$];
  bit        dropped_seen;
  result_t   batch_out[$];
  result_t   sorted_q[$];

  int        err_count;
  int        cycle_count;
  int        stall_left;
  bit        out_beat;
  bit        quiet;
  stim_row_t dir_rows [DIR_ROWS];

  iterative_quicksort #(
    .MAX_ELEMS(ELEMS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .value_i       (value_i),
    .last_i        (last_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .sorted_value_o(sorted_value_o),
    .last_res_o    (last_res_o),
    .truncated_o   (truncated_o)
  );

  // Free-running clock with a period of 10.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH: %s", msg);
    err_count++;
  endtask

  // Stores one element; on the final beat the batch is sorted ascending
  // and its output beats are placed in batch_out.
  function automatic void take_element(input word_t v, input logic l);
    word_t ordered[$];
    int    idx;
    if (held_q.size() < ELEMS) begin
      held_q.push_back(v);
    end else begin
      dropped_seen = 1'b1;
    end
    if (l) begin
      foreach (held_q[k]) begin
        idx = 0;
        while (idx < ordered.size() && ordered[idx] <= held_q[k]) idx++;
        ordered.insert(idx, held_q[k]);
      end
      foreach (ordered[k]) begin
        batch_out.push_back('{ordered[k], (k == ordered.size() - 1), dropped_seen});
      end
      held_q.delete();
      dropped_seen = 1'b0;
    end
  endfunction

  // Sends one input beat after a random gap and records what it predicts.
  // A typed row replaces the predicted value and flag with the table's.
  task automatic send_beat(input word_t v, input logic l, input bit typed,
                           input word_t exp_v, input logic exp_t);
    int      gap;
    bit      taken;
    result_t r;
    gap = quiet ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    value_i    <= v;
    last_i     <= l;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk_i);
      taken = !in_stall_o;
    end
    take_element(v, l);
    if (l) begin
      foreach (batch_out[k]) begin
        r = batch_out[k];
        if (typed) begin
          r.value = exp_v;
          r.trunc = exp_t;
        end
        sorted_q.push_back(r);
      end
      batch_out.delete();
    end
    @(negedge clk_i);
  endtask

  // Holds the sender back until every expected beat has arrived.
  task automatic wait_drain();
    in_valid_i <= 1'b0;
    while (sorted_q.size() != 0) @(negedge clk_i);
  endtask

  // Picks a value for element k of a batch in the given style.
  function automatic word_t pick_value(input int mode, input int k, input word_t base);
    int d;
    case (mode)
      0: begin
        return word_t'($urandom);
      end
      1: begin
        d = $urandom_range(0, 8);
        return word_t'(d - 4);
      end
      2: begin
        d = $urandom_range(0, 4);
        case (d)
          0: return WORD_MIN;
          1: return WORD_MAX;
          2: return word_t'(-1);
          3: return word_t'(1);
          default: return '0;
        endcase
      end
      3: begin
        return base + word_t'(k);
      end
      default: begin
        return base - word_t'(k);
      end
    endcase
  endfunction

  // Receiver stall: a fresh random wait is drawn after each beat.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_beat) begin
        stall_left = quiet ? 0 : $urandom_range(0, 19);
        out_beat   = 1'b0;
      end
      if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Output check: every accepted beat is compared with the oldest expectation.
  always @(posedge clk_i) begin : check_out
    result_t head;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      out_beat = 1'b1;
      if (sorted_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result %0d", sorted_value_o));
      end else begin
        head = sorted_q.pop_front();
        if (sorted_value_o !== head.value)
          report_mismatch($sformatf("sorted_value %0d, expected %0d",
                                    sorted_value_o, head.value));
        if (last_res_o !== head.last)
          report_mismatch($sformatf("last_res %b, expected %b", last_res_o, head.last));
        if (truncated_o !== head.trunc)
          report_mismatch($sformatf("truncated %b, expected %b", truncated_o, head.trunc));
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Main sequence: reset, directed table, random batches, drain.
  initial begin : main_seq
    int    items;
    int    batch;
    int    size;
    int    mode;
    word_t base;
    err_count    = 0;
    cycle_count  = 0;
    stall_left   = 0;
    out_beat     = 1'b0;
    dropped_seen = 1'b0;
    quiet        = 1'b1;

    // Single-element batches at the extremes, mixed signs, duplicates,
    // reversed and ordered runs, a full store that drops the final value,
    // and a short batch right after it to see the drop flag cleared.
    dir_rows = '{
      '{WORD_MAX, 1'b1, 1,  1'b1, WORD_MAX, 1'b0},
      '{WORD_MIN, 1'b1, 1,  1'b1, WORD_MIN, 1'b0},
      '{'0,       1'b1, 1,  1'b1, '0,       1'b0},
      '{WORD_MAX, 1'b0, 1,  1'b0, '0,       1'b0},
      '{WORD_MIN, 1'b0, 1,  1'b0, '0,       1'b0},
      '{-32'sd1,  1'b0, 1,  1'b0, '0,       1'b0},
      '{32'sd1,   1'b0, 1,  1'b0, '0,       1'b0},
      '{'0,       1'b1, 1,  1'b0, '0,       1'b0},
      '{32'sd7,   1'b0, 3,  1'b0, '0,       1'b0},
      '{32'sd7,   1'b1, 1,  1'b1, 32'sd7,   1'b0},
      '{32'sd3,   1'b0, 1,  1'b0, '0,       1'b0},
      '{32'sd2,   1'b0, 1,  1'b0, '0,       1'b0},
      '{32'sd1,   1'b0, 1,  1'b0, '0,       1'b0},
      '{'0,       1'b1, 1,  1'b0, '0,       1'b0},
      '{-32'sd3,  1'b0, 1,  1'b0, '0,       1'b0},
      '{-32'sd2,  1'b0, 1,  1'b0, '0,       1'b0},
      '{-32'sd1,  1'b1, 1,  1'b0, '0,       1'b0},
      '{-32'sd1,  1'b0, 64, 1'b0, '0,       1'b0},
      '{32'sd5,   1'b1, 1,  1'b1, -32'sd1,  1'b1},
      '{32'sd9,   1'b1, 1,  1'b1, 32'sd9,   1'b0}
    };

    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part: the first rows run back to back, the rest with gaps.
    for (int i = 0; i < DIR_ROWS; i++) begin
      quiet = (i < 4);
      if (i == 17) wait_drain();
      for (int r = 0; r < dir_rows[i].reps; r++) begin
        send_beat(dir_rows[i].value,
                  (r == dir_rows[i].reps - 1) ? dir_rows[i].last : 1'b0,
                  dir_rows[i].typed && (r == dir_rows[i].reps - 1),
                  dir_rows[i].exp_value, dir_rows[i].exp_trunc);
      end
    end
    wait_drain();

    // Random part: mostly short batches, every ninth one at or past full.
    items = 0;
    batch = 0;
    while (items < RAND_ITEMS) begin
      size  = (batch % 9 == 4) ? $urandom_range(ELEMS, ELEMS + 4) : $urandom_range(1, 12);
      mode  = $urandom_range(0, 4);
      base  = word_t'($urandom);
      quiet = (batch % 5 == 2);
      for (int k = 0; k < size; k++) begin
        send_beat(pick_value(mode, k, base), (k == size - 1), 1'b0, '0, 1'b0);
        items++;
      end
      if (batch % 7 == 3) wait_drain();
      batch++;
    end
    in_valid_i <= 1'b0;
    quiet = 1'b0;

    // Let the last results come out, then allow a short tail.
    while (sorted_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (sorted_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", sorted_q.size()));

    if (err_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
